### src/dfc_pkg.sv
`default_nettype none

package dfc_pkg;

   // width of frequency, step and tuning word values
   localparam int FREQ_W = 32;

   // reset values of state and registers
   localparam logic [FREQ_W-1:0] FREQ_RESET     = 32'd1000000;
   localparam logic [FREQ_W-1:0] STEP_HZ_RESET  = 32'd1000;
   localparam logic [FREQ_W-1:0] MAX_FREQ_RESET = 32'd40000000;

   // command codes
   typedef enum logic [2:0] {
      OP_SET     = 3'd0,
      OP_UP      = 3'd1,
      OP_DOWN    = 3'd2,
      OP_ENABLE  = 3'd3,
      OP_DISABLE = 3'd4
   } opcode_type;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_STEP_HZ  = 1'b0,
      CSR_MAX_FREQ = 1'b1
   } csr_index_type;

   // command outcome handed from front to back
   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic              enabled;
      logic              load;
      logic              rejected;
   } cmd_result_type;

endpackage

`default_nettype wire

### src/dds_frequency_controller.sv
// An accepted req beat goes into the queue, then through the pipeline registers to rsp.
// Throughput: one command per cycle while not stalled; the word comes from a 5-stage
// reciprocal multiply by 1/CLK_HZ with a one-step remainder correction.
// Stalls: the pipeline holds while an rsp beat waits with rsp_tready low; req_tready
// drops once the queue holds QUEUE_DEPTH beats. Reset (synchronous, active high):
// 1000000 Hz, output disabled, step_hz 1000, max_freq 40000000, queue and pipeline empty.
`default_nettype none

module dds_frequency_controller #(
   parameter logic [31:0] CLK_HZ      = 32'd125000000,
   parameter int          QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration writes
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   // command beats
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] freq_value
   input  wire logic [2:0]  req_tuser,   // [2:0] opcode
   // result beats
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata    // [31:0] current_freq, [32] output_enabled,
                                         // [33] load_valid, [65:34] phase_incr,
                                         // [66] rejected, [71:67] zero
);

   logic                          push_valid;
   logic                          push_ready;
   dfc_pkg::cmd_result_type       push_data;
   logic                          pop_valid;
   logic                          pop_ready;
   dfc_pkg::cmd_result_type       pop_data;
   dfc_pkg::cmd_result_type       rsp_info;
   logic [dfc_pkg::FREQ_W-1:0]    rsp_word;

   // command decode and frequency state
   dfc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_opcode     (req_tuser),
      .req_freq_value (req_tdata),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data)
   );

   // decoupling queue
   dfc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // tuning word conversion
   dfc_back #(
      .CLK_HZ (CLK_HZ)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_info  (rsp_info),
      .rsp_word  (rsp_word)
   );

   // result packing
   assign rsp_tdata = {5'b0, rsp_info.rejected, rsp_word, rsp_info.load,
                       rsp_info.enabled, rsp_info.freq};

endmodule

`default_nettype wire

### src/dfc_front.sv
`default_nettype none

module dfc_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [0:0]                    csr_index,
   input  wire logic [dfc_pkg::FREQ_W-1:0]    csr_wdata,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [2:0]                    req_opcode,
   input  wire logic [dfc_pkg::FREQ_W-1:0]    req_freq_value,
   output logic                               push_valid,
   input  wire logic                          push_ready,
   output dfc_pkg::cmd_result_type            push_data
);

   logic [dfc_pkg::FREQ_W-1:0] step_hz_ff, step_hz_in;
   logic [dfc_pkg::FREQ_W-1:0] max_freq_ff, max_freq_in;
   logic [dfc_pkg::FREQ_W-1:0] freq_ff, freq_in;
   logic                       enabled_ff, enabled_in;

   logic                       accept;
   logic [dfc_pkg::FREQ_W:0]   up_sum;
   logic [dfc_pkg::FREQ_W-1:0] up_freq;
   logic [dfc_pkg::FREQ_W-1:0] down_freq;
   logic [dfc_pkg::FREQ_W-1:0] next_freq;
   logic                       next_enabled;
   logic                       load;
   logic                       rejected;

   assign accept     = req_tvalid && push_ready;
   assign req_tready = push_ready;

   // saturating step arithmetic
   assign up_sum    = {1'b0, freq_ff} + {1'b0, step_hz_ff};
   assign up_freq   = (up_sum <= {1'b0, max_freq_ff}) ? up_sum[dfc_pkg::FREQ_W-1:0]
                                                      : max_freq_ff;
   assign down_freq = (freq_ff >= step_hz_ff) ? (freq_ff - step_hz_ff) : '0;

   // command decode
   always_comb begin
      next_freq    = freq_ff;
      next_enabled = enabled_ff;
      load         = 1'b0;
      rejected     = 1'b0;
      unique case (dfc_pkg::opcode_type'(req_opcode))
         dfc_pkg::OP_SET: begin
            if (req_freq_value <= max_freq_ff) begin
               next_freq = req_freq_value;
               load      = enabled_ff;
            end else begin
               rejected  = 1'b1;
            end
         end
         dfc_pkg::OP_UP: begin
            next_freq = up_freq;
            load      = enabled_ff;
         end
         dfc_pkg::OP_DOWN: begin
            next_freq = down_freq;
            load      = enabled_ff;
         end
         dfc_pkg::OP_ENABLE: begin
            next_enabled = 1'b1;
            load         = 1'b1;
         end
         dfc_pkg::OP_DISABLE: begin
            next_enabled = 1'b0;
            load         = 1'b1;
         end
         default: begin
            next_freq = freq_ff;
         end
      endcase
   end

   // outcome beat toward the queue
   assign push_valid         = req_tvalid;
   assign push_data.freq     = next_freq;
   assign push_data.enabled  = next_enabled;
   assign push_data.load     = load;
   assign push_data.rejected = rejected;

   // state and register next values
   always_comb begin
      freq_in     = accept ? next_freq : freq_ff;
      enabled_in  = accept ? next_enabled : enabled_ff;
      step_hz_in  = step_hz_ff;
      max_freq_in = max_freq_ff;
      if (csr_we) begin
         unique case (dfc_pkg::csr_index_type'(csr_index))
            dfc_pkg::CSR_STEP_HZ:  step_hz_in  = csr_wdata;
            dfc_pkg::CSR_MAX_FREQ: max_freq_in = csr_wdata;
            default:               step_hz_in  = step_hz_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff     <= dfc_pkg::FREQ_RESET;
         enabled_ff  <= 1'b0;
         step_hz_ff  <= dfc_pkg::STEP_HZ_RESET;
         max_freq_ff <= dfc_pkg::MAX_FREQ_RESET;
      end else begin
         freq_ff     <= freq_in;
         enabled_ff  <= enabled_in;
         step_hz_ff  <= step_hz_in;
         max_freq_ff <= max_freq_in;
      end
   end

endmodule

`default_nettype wire

### src/dfc_queue.sv
`default_nettype none

module dfc_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push_valid,
   output logic                          push_ready,
   input  wire dfc_pkg::cmd_result_type  push_data,
   output logic                          pop_valid,
   input  wire logic                     pop_ready,
   output dfc_pkg::cmd_result_type       pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   dfc_pkg::cmd_result_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_ready && pop_valid;

   // pointer and fill count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### src/dfc_back.sv
`default_nettype none

module dfc_back #(
   parameter logic [31:0] CLK_HZ = 32'd125000000
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          pop_valid,
   output logic                               pop_ready,
   input  wire dfc_pkg::cmd_result_type       pop_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output dfc_pkg::cmd_result_type            rsp_info,
   output logic [dfc_pkg::FREQ_W-1:0]         rsp_word
);

   localparam int STAGES = 4;
   localparam int W      = dfc_pkg::FREQ_W;

   // floor((2^64 - 1) / CLK_HZ), in two 32-bit halves
   localparam logic [63:0]  RECIP    = 64'hFFFF_FFFF_FFFF_FFFF / {32'd0, CLK_HZ};
   localparam logic [W-1:0] RECIP_HI = RECIP[63:32];
   localparam logic [W-1:0] RECIP_LO = RECIP[31:0];

   logic                    valid_ff [STAGES+1];
   logic                    valid_in [STAGES+1];
   dfc_pkg::cmd_result_type info_ff  [STAGES+1];
   dfc_pkg::cmd_result_type info_in  [STAGES+1];
   logic                    sat_ff   [STAGES];
   logic                    sat_in   [STAGES];
   logic [1:0]              fbits_ff [1:STAGES-1];
   logic [1:0]              fbits_in [1:STAGES-1];

   logic [W-1:0]   freq_ff, freq_in;
   logic [W-1:0]   hi_part_ff, hi_part_in;
   logic [W-1:0]   lo_part_ff, lo_part_in;
   logic [W-1:0]   est_s2_ff, est_s2_in;
   logic [W-1:0]   est_s3_ff, est_s3_in;
   logic [W+1:0]   prod_s3_ff, prod_s3_in;
   logic [W-1:0]   word_ff, word_in;

   logic [W-1:0]   hi_prod;
   logic [2*W-1:0] lo_prod;
   logic [W+1:0]   clk_prod;
   logic [W+1:0]   rem;
   logic           round_up;
   logic           advance;
   logic           need_word;

   // whole pipeline moves unless the output beat is stalled
   assign advance   = !valid_ff[STAGES] || rsp_ready;
   assign pop_ready = advance;

   // 32 x 32 products: only the bits that reach the estimate are kept
   assign hi_prod  = freq_ff * RECIP_HI;
   assign lo_prod  = (2*W)'(freq_ff) * (2*W)'(RECIP_LO);
   assign clk_prod = (W+2)'(est_s2_ff) * (W+2)'(CLK_HZ);

   // remainder of freq * 2^32 after the estimate, exact in 34 bits
   assign rem      = {fbits_ff[STAGES-1], {W{1'b0}}} - prod_s3_ff;
   assign round_up = (rem >= {2'b00, CLK_HZ});

   // reciprocal estimate, back-multiply and one-step correction
   always_comb begin
      valid_in[0] = pop_valid;
      info_in[0]  = pop_data;
      sat_in[0]   = (pop_data.freq >= CLK_HZ);
      freq_in     = sat_in[0] ? '0 : pop_data.freq;
      for (int k = 1; k <= STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
         info_in[k]  = info_ff[k-1];
      end
      for (int k = 1; k < STAGES; k++) begin
         sat_in[k] = sat_ff[k-1];
      end
      hi_part_in  = hi_prod;
      lo_part_in  = lo_prod[2*W-1:W];
      fbits_in[1] = freq_ff[1:0];
      est_s2_in   = hi_part_ff + lo_part_ff;
      fbits_in[2] = fbits_ff[1];
      est_s3_in   = est_s2_ff;
      prod_s3_in  = clk_prod;
      fbits_in[3] = fbits_ff[2];
      word_in     = sat_ff[STAGES-1] ? '1 : (est_s3_ff + W'(round_up));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= STAGES; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         for (int k = 0; k <= STAGES; k++) begin
            valid_ff[k] <= valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k <= STAGES; k++) begin
            info_ff[k] <= info_in[k];
         end
         for (int k = 0; k < STAGES; k++) begin
            sat_ff[k] <= sat_in[k];
         end
         for (int k = 1; k < STAGES; k++) begin
            fbits_ff[k] <= fbits_in[k];
         end
         freq_ff    <= freq_in;
         hi_part_ff <= hi_part_in;
         lo_part_ff <= lo_part_in;
         est_s2_ff  <= est_s2_in;
         est_s3_ff  <= est_s3_in;
         prod_s3_ff <= prod_s3_in;
         word_ff    <= word_in;
      end
   end

   // result beat: word only when a load to a running output
   assign need_word = info_ff[STAGES].load && info_ff[STAGES].enabled;
   assign rsp_valid = valid_ff[STAGES];
   assign rsp_info  = info_ff[STAGES];
   assign rsp_word  = need_word ? word_ff : '0;

endmodule

`default_nettype wire
